/* hdl/bhp_pkg.sv */
// Shared types, state codes, transition table and digit helpers for the heading parser.
package bhp_pkg;

	localparam int OFFSET_BITS_DEF = 16;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       first_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [15:0] heading_start;
		logic [15:0] heading_length;
		logic [1:0]  hdr_form;
		logic [31:0] ttaa;
		logic [6:0]  ii_num;
		logic [31:0] cccc;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [23:0] bbb;
	} out_item_t;

	typedef enum logic [2:0] {
		CLS_LF    = 3'd0,
		CLS_CR    = 3'd1,
		CLS_SP    = 3'd2,
		CLS_NUM   = 3'd3,
		CLS_ALPHA = 3'd4,
		CLS_OTHER = 3'd5
	} cls_t;

	localparam logic [4:0] ST_START  = 5'd0;
	localparam logic [4:0] ST_TTAA   = 5'd4;
	localparam logic [4:0] ST_II1    = 5'd5;
	localparam logic [4:0] ST_II2    = 5'd6;
	localparam logic [4:0] ST_SP1    = 5'd7;
	localparam logic [4:0] ST_CC1    = 5'd8;
	localparam logic [4:0] ST_CC4    = 5'd11;
	localparam logic [4:0] ST_SP2    = 5'd12;
	localparam logic [4:0] ST_TIME1  = 5'd13;
	localparam logic [4:0] ST_TIME6  = 5'd18;
	localparam logic [4:0] ST_SP3    = 5'd19;
	localparam logic [4:0] ST_BBB1   = 5'd20;
	localparam logic [4:0] ST_BBB3   = 5'd22;
	localparam logic [4:0] ST_END    = 5'd26;

	// rows: LF, CR, space, digit, letter; columns: current state
	localparam logic [4:0] NEXT_TBL [0:4][0:26] = '{
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
		  5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd26, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
		  5'd0, 5'd0, 5'd0, 5'd0, 5'd24, 5'd24, 5'd0, 5'd0, 5'd24, 5'd24, 5'd25, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd7, 5'd0, 5'd7, 5'd7, 5'd0, 5'd0, 5'd0, 5'd12, 5'd12, 5'd0,
		  5'd0, 5'd0, 5'd0, 5'd0, 5'd19, 5'd19, 5'd0, 5'd0, 5'd23, 5'd23, 5'd0, 5'd0, 5'd0},
		'{5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd6, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd13, 5'd14,
		  5'd15, 5'd16, 5'd17, 5'd18, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		'{5'd1, 5'd2, 5'd3, 5'd4, 5'd4, 5'd0, 5'd0, 5'd8, 5'd9, 5'd10, 5'd11, 5'd4, 5'd8, 5'd0,
		  5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd20, 5'd21, 5'd22, 5'd4, 5'd0, 5'd0, 5'd0, 5'd0}
	};

	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		if (c == 8'h0A)
			r = CLS_LF;
		else if (c == 8'h0D)
			r = CLS_CR;
		else if (c == 8'h20 || c == 8'h09)
			r = CLS_SP;
		else if (c >= 8'h30 && c <= 8'h39)
			r = CLS_NUM;
		else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
			r = CLS_ALPHA;
		else
			r = CLS_OTHER;
		return r;
	endfunction

	function automatic logic [3:0] digit(input logic [7:0] c);
		logic [7:0] d;
		d = c - 8'h30;
		return (c >= 8'h30 && c <= 8'h39) ? d[3:0] : 4'd0;
	endfunction

	// tens*10 + units, at most 99
	function automatic logic [6:0] dec_pair(input logic [7:0] hi, input logic [7:0] lo);
		logic [6:0] t;
		t = {3'd0, digit(hi)};
		return (t << 3) + (t << 1) + {3'd0, digit(lo)};
	endfunction

endpackage

/* hdl/bhp_core.sv */
// Heading parser state: byte classing, table-driven next state, field capture and result build.
module bhp_core #(
	parameter int OFFSET_BITS = bhp_pkg::OFFSET_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  bhp_pkg::in_item_t   item,
	output logic                res_valid,
	output bhp_pkg::out_item_t  res
);
	import bhp_pkg::*;

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

	logic [4:0]             state_q;
	logic [OFFSET_BITS-1:0] byte_offset_q;
	logic [31:0]            recent_q;
	logic [OFFSET_BITS-1:0] ttaa_offset_q;
	logic [OFFSET_BITS-1:0] station_offset_q;
	logic [1:0]             type_flags_q;
	logic [31:0]            ttaa_chars_q;
	logic [15:0]            ii_chars_q;
	logic [31:0]            station_chars_q;
	logic [47:0]            time_digits_q;
	logic [23:0]            bbb_chars_q;

	logic [7:0]             b;
	cls_t                   cls;
	logic [4:0]             cur;
	logic [4:0]             nxt;
	logic [OFFSET_BITS-1:0] off;
	logic [31:0]            recent;
	logic [1:0]             flags;
	logic                   ended;

	logic [4:0]             state_d;
	logic [OFFSET_BITS-1:0] byte_offset_d;
	logic [OFFSET_BITS-1:0] ttaa_offset_d;
	logic [OFFSET_BITS-1:0] station_offset_d;
	logic [1:0]             type_flags_d;
	logic [31:0]            ttaa_chars_d;
	logic [15:0]            ii_chars_d;
	logic [31:0]            station_chars_d;
	logic [47:0]            time_digits_d;
	logic [23:0]            bbb_chars_d;

	logic [OFFSET_BITS:0]   len;
	logic [32:0]            len_w;
	logic [31:0]            start_w;

	always_comb begin
		b      = item.in_byte;
		cls    = classify(b);
		cur    = item.first_byte ? ST_START : state_q;
		if (cur > ST_END)
			cur = ST_START;
		off    = item.first_byte ? '0 : byte_offset_q;
		recent = item.first_byte ? 32'd0 : recent_q;
		flags  = item.first_byte ? 2'd0 : type_flags_q;
		nxt    = (cls == CLS_OTHER) ? ST_START : NEXT_TBL[cls][cur];
		ended  = (nxt == ST_END);

		ttaa_offset_d    = ttaa_offset_q;
		ttaa_chars_d     = ttaa_chars_q;
		station_offset_d = station_offset_q;
		type_flags_d     = flags;
		if ((nxt == ST_II1 || nxt == ST_SP1) && (cur == ST_TTAA || cur == ST_CC4)) begin
			ttaa_offset_d = (off >= OFFSET_BITS'(4)) ? off - OFFSET_BITS'(4) : '0;
			ttaa_chars_d  = recent;
			type_flags_d  = (nxt == ST_SP1 && cur == ST_TTAA) ? 2'd1 : 2'd0;
		end else if (nxt == ST_CC1 && cur == ST_SP2) begin
			// second letter run after a space: the old station was really TTAA
			ttaa_offset_d    = station_offset_q;
			ttaa_chars_d     = station_chars_q;
			station_offset_d = off;
			type_flags_d     = 2'd1;
		end else if (nxt == ST_CC1 && cur == ST_SP1) begin
			station_offset_d = off;
		end else if (nxt == ST_BBB1 && cur == ST_SP3) begin
			type_flags_d = flags | 2'd2;
		end

		ii_chars_d      = ii_chars_q;
		station_chars_d = station_chars_q;
		time_digits_d   = time_digits_q;
		bbb_chars_d     = bbb_chars_q;
		if (nxt == ST_TTAA) begin
			ii_chars_d      = '0;
			station_chars_d = '0;
			time_digits_d   = '0;
			bbb_chars_d     = '0;
		end else if (nxt == ST_II1 || nxt == ST_II2) begin
			ii_chars_d = {ii_chars_q[7:0], b};
		end else if (nxt >= ST_CC1 && nxt <= ST_CC4) begin
			station_chars_d = {station_chars_q[23:0], b};
		end else if (nxt >= ST_TIME1 && nxt <= ST_TIME6) begin
			time_digits_d = {time_digits_q[39:0], b};
		end else if (nxt >= ST_BBB1 && nxt <= ST_BBB3) begin
			bbb_chars_d = {bbb_chars_q[15:0], b};
		end

		state_d       = ended ? ST_START : nxt;
		byte_offset_d = (off != OFF_MAX) ? off + OFFSET_BITS'(1) : off;
		if (item.last_byte) begin
			state_d       = ST_START;
			byte_offset_d = '0;
		end

		len = {1'b0, off} - {1'b0, ttaa_offset_q} + (OFFSET_BITS+1)'(1);
		if (ttaa_offset_q > off)
			len = '0;
		len_w   = 33'(len);
		start_w = 32'(ttaa_offset_q);

		res = '0;
		if (ended) begin
			res.found          = 1'b1;
			res.heading_start  = start_w[15:0];
			res.heading_length = (len_w > 33'd65535) ? 16'hFFFF : len_w[15:0];
			res.hdr_form       = type_flags_q;
			res.ttaa           = ttaa_chars_q;
			res.ii_num         = type_flags_q[0] ? 7'd0 :
			                     dec_pair(ii_chars_q[15:8], ii_chars_q[7:0]);
			res.cccc           = station_chars_q;
			res.day            = dec_pair(time_digits_q[47:40], time_digits_q[39:32]);
			res.hour           = dec_pair(time_digits_q[31:24], time_digits_q[23:16]);
			res.minute         = dec_pair(time_digits_q[15:8], time_digits_q[7:0]);
			res.bbb            = type_flags_q[1] ? bbb_chars_q : 24'd0;
		end
		// not-found result is all zeros
		res_valid = ended || item.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_START;
			byte_offset_q    <= '0;
			recent_q         <= '0;
			ttaa_offset_q    <= '0;
			station_offset_q <= '0;
			type_flags_q     <= '0;
			ttaa_chars_q     <= '0;
			ii_chars_q       <= '0;
			station_chars_q  <= '0;
			time_digits_q    <= '0;
			bbb_chars_q      <= '0;
		end else if (step) begin
			state_q          <= state_d;
			byte_offset_q    <= byte_offset_d;
			recent_q         <= {recent[23:0], b};
			ttaa_offset_q    <= ttaa_offset_d;
			station_offset_q <= station_offset_d;
			type_flags_q     <= type_flags_d;
			ttaa_chars_q     <= ttaa_chars_d;
			ii_chars_q       <= ii_chars_d;
			station_chars_q  <= station_chars_d;
			time_digits_q    <= time_digits_d;
			bbb_chars_q      <= bbb_chars_d;
		end
	end

endmodule

/* hdl/bulletin_heading_parser.sv */
// Top level of the abbreviated bulletin heading parser: input register, parser core, result register.
// Scans one byte per clock for a heading of the form TTAAii CCCC YYGGgg [BBB] CR CR LF and
// delivers one result when a heading ends, or a not-found result (all fields zero) on a
// last_byte with no heading end. A byte waits in the input register until the result register
// has room and its result is then registered onto out_item; a new byte is taken every cycle as
// long as the result register drains, the limit being the state update of the transition table.
// first_byte restarts the search and the offset count; offsets saturate at OFFSET_BITS ones.
module bulletin_heading_parser #(
	parameter int OFFSET_BITS = bhp_pkg::OFFSET_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bhp_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output bhp_pkg::out_item_t out_item
);
	import bhp_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      advance;
	logic      step;
	logic      res_valid;
	out_item_t res;
	logic      out_valid_q;
	out_item_t out_item_q;

	// the stage-1 byte moves on only when the result register has room
	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_item;
	end

	bhp_core #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (item_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid)
			out_item_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
